FILE: sv/coverage_mask_over_blend_assert.svh
// assertion macros for the coverage mask over blend block
`ifndef COVERAGE_MASK_OVER_BLEND_ASSERT_SVH
`define COVERAGE_MASK_OVER_BLEND_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define CMOB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CMOB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cmob_pkg.sv
`default_nettype none

package cmob_pkg;

	// largest usable image dimension, larger register values saturate here
	localparam logic [12:0] MAX_DIM = 13'd4096;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_ORIGIN_X     = 3'd2,
		REG_ORIGIN_Y     = 3'd3,
		REG_COLOR_RED    = 3'd4,
		REG_COLOR_GREEN  = 3'd5,
		REG_COLOR_BLUE   = 3'd6,
		REG_COLOR_ALPHA  = 3'd7
	} reg_index_t;

	// one coverage sample with the destination pixel under it
	typedef struct packed {
		logic [11:0] src_col;
		logic [11:0] src_row;
		logic [7:0]  coverage;
		logic [7:0]  dst_red;
		logic [7:0]  dst_green;
		logic [7:0]  dst_blue;
		logic [7:0]  dst_alpha;
		logic        last_sample;
	} sample_t;

	// one blended destination pixel
	typedef struct packed {
		logic        write_enable;
		logic [23:0] pixel_index;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [7:0]  out_alpha;
		logic        last_out;
	} pixel_t;

	// floor(x / 255), exact for every x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] t;
		t = x + {8'd0, x[15:8]} + 16'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

FILE: sv/coverage_mask_over_blend.sv
// Coverage mask over blend: each request carries one glyph coverage byte, its position in the
// glyph and the destination RGBA pixel under it; the block places it at origin plus position,
// clips to the image, scales the text alpha by the coverage and composites the text color
// over the destination, all channels 8 bit with truncating division by 255. Pixels outside
// the image come back with write_enable low, index zero and the destination unchanged.
// The datapath is a four stage pipeline (position and alpha product, scaled alpha and row
// multiply, channel products, division by 255), and one sample is taken every clock while the
// output is drained. A stall on the pixel side holds every occupied stage that has no empty
// stage ahead of it; no request is lost or repeated.
// Configuration registers sit on the APB port at byte address 4 times their index.
`default_nettype none

module coverage_mask_over_blend import cmob_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// sample channel
	input  wire logic        sample_valid,
	output logic             sample_ready,
	input  wire sample_t     sample,
	// pixel channel
	output logic             pixel_valid,
	input  wire logic        pixel_ready,
	output pixel_t           pixel
);

	// configuration registers
	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic [12:0] origin_x_q;
	logic [12:0] origin_y_q;
	logic [7:0]  color_red_q;
	logic [7:0]  color_green_q;
	logic [7:0]  color_blue_q;
	logic [7:0]  color_alpha_q;

	reg_index_t  reg_sel;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign reg_sel   = reg_index_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd1024;
			image_height_q <= 13'd1024;
			origin_x_q     <= 13'd0;
			origin_y_q     <= 13'd0;
			color_red_q    <= 8'd0;
			color_green_q  <= 8'd0;
			color_blue_q   <= 8'd0;
			color_alpha_q  <= 8'd255;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[12:0];
				REG_ORIGIN_X:     origin_x_q     <= pwdata[12:0];
				REG_ORIGIN_Y:     origin_y_q     <= pwdata[12:0];
				REG_COLOR_RED:    color_red_q    <= pwdata[7:0];
				REG_COLOR_GREEN:  color_green_q  <= pwdata[7:0];
				REG_COLOR_BLUE:   color_blue_q   <= pwdata[7:0];
				REG_COLOR_ALPHA:  color_alpha_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = {19'd0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_q};
			REG_ORIGIN_X:     prdata = {19'd0, origin_x_q};
			REG_ORIGIN_Y:     prdata = {19'd0, origin_y_q};
			REG_COLOR_RED:    prdata = {24'd0, color_red_q};
			REG_COLOR_GREEN:  prdata = {24'd0, color_green_q};
			REG_COLOR_BLUE:   prdata = {24'd0, color_blue_q};
			REG_COLOR_ALPHA:  prdata = {24'd0, color_alpha_q};
			default:          prdata = 32'd0;
		endcase
	end

	// saturated image size
	logic [12:0] width_eff;
	logic [12:0] height_eff;

	assign width_eff  = (image_width_q  > MAX_DIM) ? MAX_DIM : image_width_q;
	assign height_eff = (image_height_q > MAX_DIM) ? MAX_DIM : image_height_q;

	// stage handshake, a stage moves when the next one can take its contents
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4        = !v_s4 || pixel_ready;
	assign en_s3        = !v_s3 || en_s4;
	assign en_s2        = !v_s2 || en_s3;
	assign en_s1        = !v_s1 || en_s2;
	assign sample_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: destination position, clip test and alpha times coverage
	logic signed [13:0] dx;
	logic signed [13:0] dy;
	logic               in_image;

	assign dx = $signed({origin_x_q[12], origin_x_q}) + $signed({2'b00, sample.src_col});
	assign dy = $signed({origin_y_q[12], origin_y_q}) + $signed({2'b00, sample.src_row});
	assign in_image = !dx[13] && (dx[12:0] < width_eff) && !dy[13] && (dy[12:0] < height_eff);

	logic        inside_s1;
	logic [11:0] dx_s1;
	logic [11:0] dy_s1;
	logic [15:0] prod_s1;
	logic [7:0]  dr_s1, dg_s1, db_s1, da_s1;
	logic        last_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			inside_s1 <= in_image;
			dx_s1     <= dx[11:0];
			dy_s1     <= dy[11:0];
			prod_s1   <= color_alpha_q * sample.coverage;
			dr_s1     <= sample.dst_red;
			dg_s1     <= sample.dst_green;
			db_s1     <= sample.dst_blue;
			da_s1     <= sample.dst_alpha;
			last_s1   <= sample.last_sample;
		end
	end

	// stage 2: scaled source alpha and pixel index
	logic [24:0] row_base;

	assign row_base = dy_s1 * width_eff;

	logic        inside_s2;
	logic [7:0]  sa_s2;
	logic [23:0] idx_s2;
	logic [7:0]  dr_s2, dg_s2, db_s2, da_s2;
	logic        last_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			inside_s2 <= inside_s1;
			sa_s2     <= div255(prod_s1);
			idx_s2    <= row_base[23:0] + {12'd0, dx_s1};
			dr_s2     <= dr_s1;
			dg_s2     <= dg_s1;
			db_s2     <= db_s1;
			da_s2     <= da_s1;
			last_s2   <= last_s1;
		end
	end

	// stage 3: source and destination products per channel
	logic [7:0] inv;

	assign inv = 8'd255 - sa_s2;

	logic        inside_s3;
	logic [23:0] idx_s3;
	logic [15:0] mr_s3, mg_s3, mb_s3, ma_s3;
	logic [7:0]  dr_s3, dg_s3, db_s3, da_s3;
	logic        last_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			inside_s3 <= inside_s2;
			idx_s3    <= idx_s2;
			mr_s3     <= color_red_q   * sa_s2 + dr_s2 * inv;
			mg_s3     <= color_green_q * sa_s2 + dg_s2 * inv;
			mb_s3     <= color_blue_q  * sa_s2 + db_s2 * inv;
			ma_s3     <= 8'd255        * sa_s2 + da_s2 * inv;
			dr_s3     <= dr_s2;
			dg_s3     <= dg_s2;
			db_s3     <= db_s2;
			da_s3     <= da_s2;
			last_s3   <= last_s2;
		end
	end

	// stage 4: division by 255 and suppression of clipped pixels
	pixel_t pixel_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pixel_s4.write_enable <= inside_s3;
			pixel_s4.pixel_index  <= inside_s3 ? idx_s3 : 24'd0;
			pixel_s4.out_red      <= inside_s3 ? div255(mr_s3) : dr_s3;
			pixel_s4.out_green    <= inside_s3 ? div255(mg_s3) : dg_s3;
			pixel_s4.out_blue     <= inside_s3 ? div255(mb_s3) : db_s3;
			pixel_s4.out_alpha    <= inside_s3 ? div255(ma_s3) : da_s3;
			pixel_s4.last_out     <= last_s3;
		end
	end

	assign pixel_valid = v_s4;
	assign pixel       = pixel_s4;

	// checks
	`include "coverage_mask_over_blend_assert.svh"

	`CMOB_ASSERT(a_clip_zero_index, (pixel_valid && !pixel.write_enable) |-> (pixel.pixel_index == 24'd0), "clipped pixel carries a nonzero index")
	`CMOB_ASSERT(a_accept_fills_s1, (sample_valid && sample_ready) |=> v_s1, "accepted sample did not enter the first stage")
	`CMOB_ASSERT(a_full_stall, (v_s1 && v_s2 && v_s3 && v_s4 && !pixel_ready) |-> !sample_ready, "sample taken while the pipeline is full and stalled")
	`CMOB_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !pixel_valid, "pixel valid during reset")

endmodule

`default_nettype wire
